// ===== src/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Shared widths, default sizes and result codes of the paged staging allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

  localparam int unsigned PAGE_SLOTS_DEF = 8;
  localparam int unsigned PAGE_BYTES_DEF = 16777216;
  localparam int unsigned GROW_ALIGN_DEF = 65536;

  localparam int unsigned BYTES_W  = 32;
  localparam int unsigned ALIGN_W  = 17;
  localparam int unsigned TICKET_W = 32;
  localparam int unsigned CUR_W    = 33;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK_EXIST = 3'd0,
    ST_OK_NEW   = 3'd1,
    ST_NO_SLOT  = 3'd2,
    ST_SUBMIT   = 3'd3,
    ST_ZERO     = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== src/psa_rem.sv =====
// ----------------------------------------------------------------------------
// psa_rem
// Restoring remainder unit: one quotient bit per cycle, done pulses with rem.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_rem #(
  parameter int unsigned NUM_W = psa_pkg::CUR_W,
  parameter int unsigned DEN_W = psa_pkg::ALIGN_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [DEN_W-1:0]      rem
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;

  assign trial     = {rem, num_sh[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(NUM_W);
      end else if (active) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem    <= '0;
    end else if (active) begin
      num_sh <= num_sh << 1;
      if (trial_sub[DEN_W]) begin
        rem <= trial[DEN_W-1:0];
      end else begin
        rem <= trial_sub[DEN_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/paged_staging_allocator_top.sv =====
// ----------------------------------------------------------------------------
// paged_staging_allocator_top
// Bump allocator over staging page slots with fence-ticket page reuse.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready; one result per request leaves on
// out_valid/out_ready. in_ready is high only while the sequencer is idle.
// A submit sweeps the open slots, one per cycle. An allocate first visits
// each open slot in order; a pending slot gets a memory read, then a
// remainder step for the align-up, a non-pending slot is passed over in the
// first scan and checked against its fence ticket in the idle scan. Opening
// a new page rounds up the capacity in the same remainder unit. Zero-byte
// requests skip the scans and go straight to the output register.
// The result sits in an output register; the next request is taken while
// it waits, and a finished result waits for the register to drain.
// Reset clears the open-slot count and the pending marks; per-slot cursor,
// capacity and ticket memories are only read for slots already opened.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_staging_allocator_top #(
  parameter int unsigned PAGE_SLOTS = psa_pkg::PAGE_SLOTS_DEF,
  parameter int unsigned PAGE_BYTES = psa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned GROW_ALIGN = psa_pkg::GROW_ALIGN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          func,
  input  wire logic [psa_pkg::BYTES_W-1:0]   byte_count,
  input  wire logic [psa_pkg::ALIGN_W-1:0]   alignment,
  input  wire logic [psa_pkg::TICKET_W-1:0]  completed_ticket,
  input  wire logic [psa_pkg::TICKET_W-1:0]  submit_ticket,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [psa_pkg::STATUS_W-1:0]       status,
  output logic [psa_pkg::INDEX_W-1:0]        page_index,
  output logic [psa_pkg::CUR_W-1:0]          offset
);

  localparam int unsigned CUR_W  = psa_pkg::CUR_W;
  localparam int unsigned TKT_W  = psa_pkg::TICKET_W;
  localparam int unsigned SW     = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int unsigned CW     = SW + 1;
  localparam int unsigned GROW_W = $clog2(GROW_ALIGN + 1);
  localparam int unsigned DEN_W  = (GROW_W > psa_pkg::ALIGN_W) ? GROW_W : psa_pkg::ALIGN_W;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_SUB     = 10'b00_0000_0010,
    S_P_RD    = 10'b00_0000_0100,
    S_P_START = 10'b00_0000_1000,
    S_P_WAIT  = 10'b00_0001_0000,
    S_I_RD    = 10'b00_0010_0000,
    S_I_CHK   = 10'b00_0100_0000,
    S_N_START = 10'b00_1000_0000,
    S_N_WAIT  = 10'b01_0000_0000,
    S_EMIT    = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]         slot, slot_next;
  logic [CW-1:0]         n, n_next;
  logic [PAGE_SLOTS-1:0] pending, pending_next;
  logic [SW-1:0]         idx;

  logic [psa_pkg::BYTES_W-1:0] bytes_q;
  logic [psa_pkg::ALIGN_W-1:0] align_q;
  logic [TKT_W-1:0]            done_q;
  logic [TKT_W-1:0]            stamp_q;

  psa_pkg::status_t     res_status, res_status_next;
  logic [CW-1:0]        res_slot, res_slot_next;
  logic [CUR_W-1:0]     res_off, res_off_next;

  logic [CUR_W-1:0] cur_mem [PAGE_SLOTS];
  logic [CUR_W-1:0] cap_mem [PAGE_SLOTS];
  logic [TKT_W-1:0] tkt_mem [PAGE_SLOTS];
  logic [CUR_W-1:0] cur_q, cap_q;
  logic [TKT_W-1:0] tkt_q;

  logic             cur_we, cap_we, tkt_we;
  logic [CUR_W-1:0] cur_wdata, cap_wdata;
  logic [TKT_W-1:0] tkt_wdata;

  logic             div_start, div_done;
  logic             grow_phase;
  logic [CUR_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [DEN_W-1:0] div_rem;
  logic [DEN_W-1:0] gap;
  logic [CUR_W:0]   up_sum;
  logic [CUR_W-1:0] aligned;
  logic [CUR_W-1:0] cap_new;
  logic [CUR_W:0]   room;
  logic             fit;

  assign idx = slot[SW-1:0];

  // remainder unit, shared by the align-up and the capacity round-up
  assign grow_phase = (state == S_N_START) || (state == S_N_WAIT);
  assign div_num    = grow_phase ? CUR_W'(bytes_q) : cur_q;
  assign div_den    = grow_phase ? DEN_W'(GROW_ALIGN) :
                      ((align_q == '0) ? DEN_W'(1) : DEN_W'(align_q));

  psa_rem #(
    .NUM_W (CUR_W),
    .DEN_W (DEN_W)
  ) u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .rem   (div_rem)
  );

  assign gap     = (div_rem == '0) ? '0 : (div_den - div_rem);
  assign up_sum  = {1'b0, div_num} + (CUR_W+1)'(gap);
  assign aligned = up_sum[CUR_W-1:0];
  assign cap_new = (aligned < CUR_W'(PAGE_BYTES)) ? CUR_W'(PAGE_BYTES) : aligned;
  assign room    = {1'b0, cap_q} - {1'b0, aligned};
  assign fit     = !room[CUR_W] && ((CUR_W+1)'(bytes_q) <= room);

  always_ff @(posedge clk) begin
    cur_q <= cur_mem[idx];
    cap_q <= cap_mem[idx];
    tkt_q <= tkt_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[idx] <= cur_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem[idx] <= cap_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (tkt_we) begin
      tkt_mem[idx] <= tkt_wdata;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    slot_next       = slot;
    n_next          = n;
    pending_next    = pending;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_off_next    = res_off;
    div_start       = 1'b0;
    cur_we          = 1'b0;
    cur_wdata       = '0;
    cap_we          = 1'b0;
    cap_wdata       = '0;
    tkt_we          = 1'b0;
    tkt_wdata       = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          slot_next = '0;
          if (func) begin
            state_next = S_SUB;
          end else if (byte_count == '0) begin
            res_status_next = psa_pkg::ST_ZERO;
            res_slot_next   = '0;
            res_off_next    = '0;
            state_next      = S_EMIT;
          end else begin
            state_next = S_P_RD;
          end
        end
      end
      S_SUB: begin
        if (slot >= n) begin
          res_status_next = psa_pkg::ST_SUBMIT;
          res_slot_next   = '0;
          res_off_next    = '0;
          state_next      = S_EMIT;
        end else begin
          if (pending[idx]) begin
            tkt_we            = 1'b1;
            tkt_wdata         = stamp_q;
            pending_next[idx] = 1'b0;
          end
          slot_next = slot + CW'(1);
        end
      end
      S_P_RD: begin
        if (slot >= n) begin
          slot_next  = '0;
          state_next = S_I_RD;
        end else if (pending[idx]) begin
          state_next = S_P_START;
        end else begin
          slot_next = slot + CW'(1);
        end
      end
      S_P_START: begin
        div_start  = 1'b1;
        state_next = S_P_WAIT;
      end
      S_P_WAIT: begin
        if (div_done) begin
          if (fit) begin
            cur_we            = 1'b1;
            cur_wdata         = aligned + CUR_W'(bytes_q);
            pending_next[idx] = 1'b1;
            res_status_next   = psa_pkg::ST_OK_EXIST;
            res_slot_next     = slot;
            res_off_next      = aligned;
            state_next        = S_EMIT;
          end else begin
            slot_next  = slot + CW'(1);
            state_next = S_P_RD;
          end
        end
      end
      S_I_RD: begin
        if (slot >= n) begin
          state_next = S_N_START;
        end else if (pending[idx]) begin
          slot_next = slot + CW'(1);
        end else begin
          state_next = S_I_CHK;
        end
      end
      S_I_CHK: begin
        if (tkt_q > done_q) begin
          slot_next  = slot + CW'(1);
          state_next = S_I_RD;
        end else begin
          tkt_we = 1'b1;
          cur_we = 1'b1;
          if (CUR_W'(bytes_q) <= cap_q) begin
            cur_wdata         = CUR_W'(bytes_q);
            pending_next[idx] = 1'b1;
            res_status_next   = psa_pkg::ST_OK_EXIST;
            res_slot_next     = slot;
            res_off_next      = '0;
            state_next        = S_EMIT;
          end else begin
            slot_next  = slot + CW'(1);
            state_next = S_I_RD;
          end
        end
      end
      S_N_START: begin
        if (n >= CW'(PAGE_SLOTS)) begin
          res_status_next = psa_pkg::ST_NO_SLOT;
          res_slot_next   = '0;
          res_off_next    = '0;
          state_next      = S_EMIT;
        end else begin
          div_start  = 1'b1;
          state_next = S_N_WAIT;
        end
      end
      S_N_WAIT: begin
        if (div_done) begin
          cap_we            = 1'b1;
          cap_wdata         = cap_new;
          cur_we            = 1'b1;
          cur_wdata         = CUR_W'(bytes_q);
          tkt_we            = 1'b1;
          pending_next[idx] = 1'b1;
          n_next            = n + CW'(1);
          res_status_next   = psa_pkg::ST_OK_NEW;
          res_slot_next     = slot;
          res_off_next      = '0;
          state_next        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      slot    <= '0;
      n       <= '0;
      pending <= '0;
    end else begin
      state   <= state_next;
      slot    <= slot_next;
      n       <= n_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_off    <= res_off_next;
    if (in_valid && in_ready) begin
      bytes_q <= byte_count;
      align_q <= alignment;
      done_q  <= completed_ticket;
      stamp_q <= submit_ticket;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!out_valid || out_ready)) begin
      status     <= res_status;
      page_index <= psa_pkg::INDEX_W'(res_slot);
      offset     <= res_off;
    end
  end

endmodule

`default_nettype wire

// ===== verif/paged_staging_allocator_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paged_staging_allocator_top_test
// Self-checking bench for the paged staging allocator.
// ----------------------------------------------------------------------------
// A directed opening covers zero-byte and zero-alignment requests, the widest
// fields, submits with nothing pending, page reuse by fence ticket and the
// no-slot-free case. Random allocate/submit batches with lagging completed
// tickets follow. A scoreboard keeps its own copy of the page table, predicts
// one result per accepted request and compares it in order. Both sides
// insert random idle cycles, with calm stretches between.
// ----------------------------------------------------------------------------

class alloc_scoreboard;

  localparam int unsigned SLOTS = psa_pkg::PAGE_SLOTS_DEF;
  localparam longint unsigned PAGE_SIZE = psa_pkg::PAGE_BYTES_DEF;
  localparam longint unsigned GROW = psa_pkg::GROW_ALIGN_DEF;
  localparam longint unsigned MASK33 = 64'h1_FFFF_FFFF;

  typedef struct {
    psa_pkg::status_t status;
    logic [psa_pkg::INDEX_W-1:0] page_index;
    logic [psa_pkg::CUR_W-1:0] offset;
  } alloc_result_t;

  longint unsigned cursor[SLOTS];
  longint unsigned capacity[SLOTS];
  bit pending[SLOTS];
  longint unsigned last_ticket[SLOTS];
  int unsigned open_pages;
  alloc_result_t expected_results[$];
  int errors;

  function new();
    for (int s = 0; s < SLOTS; s++) begin
      cursor[s] = 0;
      capacity[s] = 0;
      pending[s] = 0;
      last_ticket[s] = 0;
    end
    open_pages = 0;
    errors = 0;
  endfunction

  function longint unsigned align_up(longint unsigned v, longint unsigned a);
    return ((v + a - 1) / a) * a;
  endfunction

  function bit place(int s, longint unsigned nbytes, longint unsigned a,
                     output longint unsigned off);
    longint unsigned o;
    o = align_up(cursor[s], a);
    off = 0;
    if (o > capacity[s] || nbytes > capacity[s] - o) return 0;
    cursor[s] = (o + nbytes) & MASK33;
    pending[s] = 1;
    off = o;
    return 1;
  endfunction

  function void push(psa_pkg::status_t st, int s, longint unsigned off);
    alloc_result_t r;
    r.status = st;
    r.page_index = s[psa_pkg::INDEX_W-1:0];
    r.offset = off[psa_pkg::CUR_W-1:0];
    expected_results.insert(expected_results.size(), r);
  endfunction

  function void note_request(bit is_submit, bit [31:0] nbytes, bit [16:0] align_f,
                             bit [31:0] done, bit [31:0] stamp);
    longint unsigned a;
    longint unsigned off;
    longint unsigned cap;
    int s;
    if (is_submit) begin
      for (s = 0; s < open_pages; s++) begin
        if (pending[s]) begin
          pending[s] = 0;
          last_ticket[s] = stamp;
        end
      end
      push(psa_pkg::ST_SUBMIT, 0, 0);
      return;
    end
    if (nbytes == 0) begin
      push(psa_pkg::ST_ZERO, 0, 0);
      return;
    end
    a = (align_f == 0) ? 1 : align_f;
    for (s = 0; s < open_pages; s++) begin
      if (pending[s] && place(s, nbytes, a, off)) begin
        push(psa_pkg::ST_OK_EXIST, s, off);
        return;
      end
    end
    for (s = 0; s < open_pages; s++) begin
      if (pending[s] || last_ticket[s] > done) continue;
      cursor[s] = 0;
      last_ticket[s] = 0;
      if (place(s, nbytes, a, off)) begin
        push(psa_pkg::ST_OK_EXIST, s, off);
        return;
      end
    end
    if (open_pages >= SLOTS) begin
      push(psa_pkg::ST_NO_SLOT, 0, 0);
      return;
    end
    s = open_pages;
    cap = align_up(nbytes, GROW);
    if (cap < PAGE_SIZE) cap = PAGE_SIZE;
    capacity[s] = cap & MASK33;
    cursor[s] = 0;
    last_ticket[s] = 0;
    pending[s] = 0;
    open_pages = s + 1;
    if (!place(s, nbytes, a, off)) off = 0;
    push(psa_pkg::ST_OK_NEW, s, off);
  endfunction

  function void check_result(logic [2:0] st, logic [2:0] idx, logic [32:0] off);
    alloc_result_t r;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result status=%0d page=%0d offset=%0h",
               $time, st, idx, off);
      errors++;
      return;
    end
    r = expected_results.pop_front();
    if (st !== r.status) begin
      $display("%0t: status expected %0d actual %0d", $time, r.status, st);
      errors++;
    end
    if (idx !== r.page_index) begin
      $display("%0t: page_index expected %0d actual %0d", $time, r.page_index, idx);
      errors++;
    end
    if (off !== r.offset) begin
      $display("%0t: offset expected %0h actual %0h", $time, r.offset, off);
      errors++;
    end
  endfunction

endclass

module paged_staging_allocator_top_test;

  localparam bit FUNC_ALLOC = 1'b0;
  localparam bit FUNC_SUBMIT = 1'b1;
  localparam int RANDOM_REQUESTS = 600;
  localparam int STALL_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FUNC_ALLOC;
  logic [psa_pkg::BYTES_W-1:0] byte_count = '0;
  logic [psa_pkg::ALIGN_W-1:0] alignment = '0;
  logic [psa_pkg::TICKET_W-1:0] completed_ticket = '0;
  logic [psa_pkg::TICKET_W-1:0] submit_ticket = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [psa_pkg::STATUS_W-1:0] status;
  logic [psa_pkg::INDEX_W-1:0] page_index;
  logic [psa_pkg::CUR_W-1:0] offset;

  alloc_scoreboard sb = new();
  bit calm = 0;
  int stall_cycles = 0;

  paged_staging_allocator_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .byte_count       (byte_count),
    .alignment        (alignment),
    .completed_ticket (completed_ticket),
    .submit_ticket    (submit_ticket),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .page_index       (page_index),
    .offset           (offset)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(status, page_index, offset);
    if (!rst && in_valid && in_ready) begin
      sb.note_request(func, byte_count, alignment, completed_ticket, submit_ticket);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("paged_staging_allocator_top_test NOT OK");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    int hold;
    wait (!rst);
    @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_request(input bit f, input bit [31:0] nbytes, input bit [16:0] al,
                              input bit [31:0] done, input bit [31:0] stamp);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    byte_count <= nbytes;
    alignment <= al;
    completed_ticket <= done;
    submit_ticket <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic alloc(input bit [31:0] nbytes, input bit [16:0] al, input bit [31:0] done);
    send_request(FUNC_ALLOC, nbytes, al, done, $urandom);
  endtask

  task automatic submit(input bit [31:0] stamp);
    send_request(FUNC_SUBMIT, $urandom, 17'($urandom), $urandom, stamp);
  endtask

  initial begin
    int issued;
    int batch;
    int r;
    bit [31:0] ticket;
    bit [31:0] nbytes;
    bit [16:0] al;
    bit [31:0] done;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening
    alloc(0, 1, 0);
    submit(32'h5A5A_A5A5);
    alloc(1, 1, 0);
    alloc(100, 0, 0);
    alloc(10, 17'h10000, 0);
    alloc(5, 17'h1FFFF, 0);
    alloc(32'hFFFF_FFFF, 1, 0);
    alloc(32'h0100_0000, 4096, 0);
    submit(32'hFFFF_FFFF);
    alloc(64, 64, 5);
    submit(10);
    alloc(64, 64, 10);
    repeat (4) alloc(32'hFFFF_FFFF, 1, 0);
    alloc(32'hFFFF_FFFF, 1, 0);
    alloc(1, 1, 0);
    submit(20);
    alloc(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    alloc(32'h0100_0001, 1, 0);
    submit($urandom);
    submit($urandom);

    // random batches of allocations closed by a submit
    ticket = $urandom;
    issued = 0;
    while (issued < RANDOM_REQUESTS) begin
      if (issued % 64 < 8) calm = ($urandom_range(0, 3) == 0);
      batch = $urandom_range(1, 10);
      repeat (batch) begin
        r = $urandom_range(0, 99);
        if (r < 5) nbytes = 0;
        else if (r < 55) nbytes = $urandom_range(1, 65536);
        else if (r < 85) nbytes = $urandom_range(65537, 32'h0080_0000);
        else if (r < 97) nbytes = $urandom_range(32'h0080_0000, 32'h0280_0000);
        else nbytes = $urandom;
        r = $urandom_range(0, 99);
        if (r < 70) al = 17'd1 << $urandom_range(0, 16);
        else if (r < 85) al = 17'($urandom_range(1, 65536));
        else if (r < 95) al = 17'($urandom_range(0, 17'h1FFFF));
        else al = $urandom_range(0, 1) ? 17'h1FFFF : 17'h0;
        r = $urandom_range(0, 99);
        if (r < 80) done = ticket - $urandom_range(0, 2);
        else if (r < 90) done = ticket - $urandom_range(3, 10);
        else done = $urandom;
        alloc(nbytes, al, done);
        issued++;
      end
      r = $urandom_range(0, 99);
      if (r < 90) begin
        ticket = ticket + 1;
        submit(ticket);
      end else begin
        submit($urandom);
      end
      issued++;
      if ($urandom_range(0, 19) == 0) begin
        submit(ticket);
        issued++;
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("paged_staging_allocator_top_test OK");
    end else begin
      $display("paged_staging_allocator_top_test NOT OK");
    end
    $finish;
  end

endmodule
